// ===== rtl/core/point_to_equirect_pixel_assert.svh =====
// assertion macros for the projection block
`ifndef POINT_TO_EQUIRECT_PIXEL_ASSERT_SVH
`define POINT_TO_EQUIRECT_PIXEL_ASSERT_SVH

// checked outside reset
`define PTEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked across reset too
`define PTEP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ptep_pkg.sv =====
package ptep_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN = 24;
  localparam int CW = 36;
  localparam int AW = 34;
  localparam int VW = 56;
  localparam int NW = 31;
  localparam int IDXW = 4;
  localparam int CFGW = 63;

  localparam logic [IDXW-1:0] REG_ROT_X  = 4'd0;
  localparam logic [IDXW-1:0] REG_ROT_Y  = 4'd1;
  localparam logic [IDXW-1:0] REG_ROT_Z  = 4'd2;
  localparam logic [IDXW-1:0] REG_SHIFT_X = 4'd3;
  localparam logic [IDXW-1:0] REG_SHIFT_Y = 4'd4;
  localparam logic [IDXW-1:0] REG_SHIFT_Z = 4'd5;
  localparam logic [IDXW-1:0] REG_PANO_W = 4'd6;
  localparam logic [IDXW-1:0] REG_PANO_H = 4'd7;

  localparam logic signed [AW-1:0] HALF_TURN = 34'sd2147483648;
  localparam logic signed [AW-1:0] QUARTER_TURN = 34'sd1073741824;

  localparam logic [31:0] ATAN_TAB [0:ATAN_LEN-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
    logic signed [AW-1:0] theta;
    logic signed [NW-1:0] z;
    logic                 zero_f;
  } cord_t;

  // vectoring gain, from running the rotation on (2^30, 0)
  function automatic longint cordic_gain();
    longint x;
    longint y;
    longint dx;
    longint dy;
    x = 64'sd1073741824;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
      end else begin
        x = x - dx;
        y = y + dy;
      end
    end
    return x;
  endfunction

  localparam longint GAIN = cordic_gain();

  // fold the left half plane onto the right half
  function automatic cord_t prerot(input logic signed [CW-1:0] a,
                                   input logic signed [CW-1:0] b,
                                   input logic signed [AW-1:0] theta,
                                   input logic zero_f);
    cord_t c;
    c.x = a;
    c.y = b;
    c.ang = '0;
    c.theta = theta;
    c.z = '0;
    c.zero_f = zero_f;
    if (a < 0) begin
      if (b >= 0) begin
        c.x = b;
        c.y = -a;
        c.ang = QUARTER_TURN;
      end else begin
        c.x = -b;
        c.y = a;
        c.ang = -QUARTER_TURN;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/ptep_cordic_stage.sv =====
module ptep_cordic_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [4:0]       step,
  input  logic             vld_i,
  input  ptep_pkg::cord_t  d_i,
  output logic             vld_o,
  output ptep_pkg::cord_t  q_o
);

  logic                           vld_r;
  ptep_pkg::cord_t                q_r;
  ptep_pkg::cord_t                q_nxt;
  logic signed [ptep_pkg::CW-1:0] dx;
  logic signed [ptep_pkg::CW-1:0] dy;
  logic signed [ptep_pkg::AW-1:0] da;

  always_comb begin
    dx = d_i.y >>> step;
    dy = d_i.x >>> step;
    da = ptep_pkg::AW'(ptep_pkg::ATAN_TAB[step]);
    q_nxt = d_i;
    if (d_i.y >= 0) begin
      q_nxt.x = d_i.x + dx;
      q_nxt.y = d_i.y - dy;
      q_nxt.ang = d_i.ang + da;
    end else begin
      q_nxt.x = d_i.x - dx;
      q_nxt.y = d_i.y + dy;
      q_nxt.ang = d_i.ang - da;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign vld_o = vld_r;
  assign q_o = q_r;

endmodule

// ===== rtl/core/point_to_equirect_pixel.sv =====
// Projects 3D points (Q16.16) onto an equirectangular panorama.
// Input channel in_valid/in_ready carries in_point_x/y/z; result channel
// out_valid/out_ready carries out_pixel_col and out_pixel_row.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, indexes 0..7 select rotation rows, translation, width and
// height, other indexes are dropped. Write only while the pipeline is empty.
// The pipeline is 7 stages of transform and normalisation, 16 azimuth
// CORDIC stages, a gain multiply, a fold stage, 16 polar CORDIC stages
// and the output scaling register. Throughput is one point per cycle
// while out_ready does not stall a waiting result; each CORDIC iteration is a stage.
// Reset (synchronous, rst_n low) empties the pipeline and loads the
// identity rotation, zero translation and a 4096 x 2048 panorama.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is lost or repeated.
module point_to_equirect_pixel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            in_point_x,
  input  logic signed [31:0]            in_point_y,
  input  logic signed [31:0]            in_point_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [13:0]                   out_pixel_col,
  output logic [13:0]                   out_pixel_row,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptep_pkg::IDXW-1:0]     cfg_index,
  input  logic [ptep_pkg::CFGW-1:0]     cfg_data
);

  localparam int N = ptep_pkg::CORDIC_STEPS;
  localparam int VW = ptep_pkg::VW;
  localparam int CW = ptep_pkg::CW;
  localparam int AW = ptep_pkg::AW;
  localparam int NW = ptep_pkg::NW;

  logic [62:0]        rot_x_r, rot_y_r, rot_z_r;
  logic signed [31:0] shift_x_r, shift_y_r, shift_z_r;
  logic [13:0]        pano_w_r, pano_h_r;

  logic adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_x_r <= 63'h2000000000000000;
      rot_y_r <= 63'h0000010000000000;
      rot_z_r <= 63'h0000000000080000;
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
      pano_w_r <= 14'd4096;
      pano_h_r <= 14'd2048;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ptep_pkg::REG_ROT_X:   rot_x_r <= cfg_data;
        ptep_pkg::REG_ROT_Y:   rot_y_r <= cfg_data;
        ptep_pkg::REG_ROT_Z:   rot_z_r <= cfg_data;
        ptep_pkg::REG_SHIFT_X: shift_x_r <= cfg_data[31:0];
        ptep_pkg::REG_SHIFT_Y: shift_y_r <= cfg_data[31:0];
        ptep_pkg::REG_SHIFT_Z: shift_z_r <= cfg_data[31:0];
        ptep_pkg::REG_PANO_W:  pano_w_r <= cfg_data[13:0];
        ptep_pkg::REG_PANO_H:  pano_h_r <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // stage valid bits: products, sums, magnitudes, max, msb, normalise, fold
  logic [6:0] vld_r;
  logic       mul_vld_r, fold_vld_r, out_vld_r;
  logic       th_v [0:N];
  logic       ph_v [0:N];

  assign adv = !out_vld_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      mul_vld_r <= 1'b0;
      fold_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[5:0], in_valid};
      mul_vld_r <= th_v[N];
      fold_vld_r <= mul_vld_r;
      out_vld_r <= ph_v[N];
    end
  end

  // products
  logic signed [52:0] prod_r [0:8];
  logic signed [52:0] prod_nxt [0:8];
  logic signed [20:0] coef [0:8];
  logic signed [31:0] pt [0:2];

  always_comb begin
    pt[0] = in_point_x;
    pt[1] = in_point_y;
    pt[2] = in_point_z;
    coef[0] = rot_x_r[62:42];
    coef[1] = rot_x_r[41:21];
    coef[2] = rot_x_r[20:0];
    coef[3] = rot_y_r[62:42];
    coef[4] = rot_y_r[41:21];
    coef[5] = rot_y_r[20:0];
    coef[6] = rot_z_r[62:42];
    coef[7] = rot_z_r[41:21];
    coef[8] = rot_z_r[20:0];
    for (int k = 0; k < 9; k++) begin
      prod_nxt[k] = 53'(coef[k]) * 53'(pt[k%3]);
    end
  end

  // row sums plus translation
  logic signed [VW-1:0] v_r [0:2];
  logic signed [VW-1:0] v_nxt [0:2];

  always_comb begin
    v_nxt[0] = VW'(prod_r[0]) + VW'(prod_r[1]) + VW'(prod_r[2]) + (VW'(shift_x_r) <<< 19);
    v_nxt[1] = VW'(prod_r[3]) + VW'(prod_r[4]) + VW'(prod_r[5]) + (VW'(shift_y_r) <<< 19);
    v_nxt[2] = VW'(prod_r[6]) + VW'(prod_r[7]) + VW'(prod_r[8]) + (VW'(shift_z_r) <<< 19);
  end

  // magnitudes, max, msb, normalise
  logic [VW-1:0] mag_r [0:2];
  logic [2:0]    neg_r;
  logic [VW-1:0] mag4_r [0:2];
  logic [2:0]    neg4_r;
  logic [VW-1:0] max_r;
  logic [VW-1:0] mag5_r [0:2];
  logic [2:0]    neg5_r;
  logic [5:0]    msb_r;
  logic [VW-1:0] max_nxt;
  logic [5:0]    msb_nxt;

  always_comb begin
    max_nxt = mag_r[0];
    if (mag_r[1] > max_nxt) max_nxt = mag_r[1];
    if (mag_r[2] > max_nxt) max_nxt = mag_r[2];
    msb_nxt = '0;
    for (int i = 0; i < VW; i++) begin
      if (max_r[i]) msb_nxt = 6'(i);
    end
  end

  logic signed [NW-1:0] n_r [0:2];
  logic signed [NW-1:0] n_nxt [0:2];
  logic [VW-1:0]        sh_tmp [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (msb_r > 6'd29) begin
        sh_tmp[k] = mag5_r[k] >> (msb_r - 6'd29);
      end else begin
        sh_tmp[k] = mag5_r[k] << (6'd29 - msb_r);
      end
      n_nxt[k] = neg5_r[k] ? -$signed({1'b0, sh_tmp[k][29:0]})
                           : $signed({1'b0, sh_tmp[k][29:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      v_r <= v_nxt;
      for (int k = 0; k < 3; k++) begin
        neg_r[k] <= v_r[k][VW-1];
        mag_r[k] <= v_r[k][VW-1] ? VW'(-v_r[k]) : VW'(v_r[k]);
      end
      mag4_r <= mag_r;
      neg4_r <= neg_r;
      max_r <= max_nxt;
      mag5_r <= mag4_r;
      neg5_r <= neg4_r;
      msb_r <= msb_nxt;
      n_r <= n_nxt;
    end
  end

  // azimuth chain
  ptep_pkg::cord_t th_d [0:N];
  ptep_pkg::cord_t th0_nxt;
  ptep_pkg::cord_t th0_r;

  always_comb begin
    th0_nxt = ptep_pkg::prerot(CW'(n_r[1]), CW'(n_r[0]), '0,
                               (n_r[0] == '0) && (n_r[1] == '0));
    th0_nxt.z = n_r[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      th0_r <= th0_nxt;
    end
  end

  assign th_d[0] = th0_r;
  assign th_v[0] = vld_r[6];

  for (genvar g = 0; g < N; g++) begin : g_th
    ptep_cordic_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .step  (5'(g)),
      .vld_i (th_v[g]),
      .d_i   (th_d[g]),
      .vld_o (th_v[g+1]),
      .q_o   (th_d[g+1])
    );
  end

  // gain scaling of z
  localparam logic signed [31:0] GAIN32 = 32'(ptep_pkg::GAIN);
  logic signed [62:0]   zprod;
  logic signed [CW-1:0] zs_r, a_r;
  logic signed [AW-1:0] theta_r;

  assign zprod = 63'(th_d[N].z) * 63'(GAIN32);

  always_ff @(posedge clk) begin
    if (adv) begin
      zs_r <= CW'(zprod >>> 30);
      a_r <= th_d[N].x;
      theta_r <= th_d[N].zero_f ? '0 : th_d[N].ang;
    end
  end

  // polar chain
  ptep_pkg::cord_t ph_d [0:N];
  ptep_pkg::cord_t ph0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ph0_r <= ptep_pkg::prerot(zs_r, a_r, theta_r, (zs_r == '0) && (a_r == '0));
    end
  end

  assign ph_d[0] = ph0_r;
  assign ph_v[0] = fold_vld_r;

  for (genvar g = 0; g < N; g++) begin : g_ph
    ptep_cordic_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .step  (5'(g)),
      .vld_i (ph_v[g]),
      .d_i   (ph_d[g]),
      .vld_o (ph_v[g+1]),
      .q_o   (ph_d[g+1])
    );
  end

  // clamp and scale to pixels
  logic signed [AW-1:0] th_c, ph_c, tpos;
  logic [46:0]          colp;
  logic [45:0]          rowp;
  logic [13:0]          col_r, row_r;

  always_comb begin
    th_c = ph_d[N].theta;
    if (th_c > ptep_pkg::HALF_TURN) th_c = ptep_pkg::HALF_TURN;
    if (th_c < -ptep_pkg::HALF_TURN) th_c = -ptep_pkg::HALF_TURN;
    ph_c = ph_d[N].zero_f ? '0 : ph_d[N].ang;
    if (ph_c > ptep_pkg::HALF_TURN) ph_c = ptep_pkg::HALF_TURN;
    if (ph_c < 0) ph_c = '0;
    tpos = th_c + ptep_pkg::HALF_TURN;
    colp = 47'(pano_w_r) * 47'(tpos[32:0]);
    rowp = 46'(pano_h_r) * 46'(ph_c[31:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_r <= colp[45:32];
      row_r <= rowp[44:31];
    end
  end

  assign out_valid = out_vld_r;
  assign out_pixel_col = col_r;
  assign out_pixel_row = row_r;

endmodule

// ===== rtl/core/ptep_check.sv =====
`include "point_to_equirect_pixel_assert.svh"

module ptep_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] out_pixel_col,
  input logic [13:0] out_pixel_row
);

  // a stalled result holds with its payload
  `PTEP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_pixel_col) && $stable(out_pixel_row), "result changed while stalled")
  // stall reaches the input side in the same cycle
  `PTEP_ASSERT(a_stall_back, out_valid && !out_ready |-> !in_ready, "input taken during stall")
  // reset empties the pipeline
  `PTEP_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result after reset")
  // ready for a transaction once reset is released
  `PTEP_ASSERT_RST(a_rst_ready, !rst_n |=> in_ready, "not ready after reset")

endmodule

bind point_to_equirect_pixel ptep_check u_ptep_check (.*);
